// File: rtl/tlg_pkg.sv
`timescale 1ns / 1ps
package tlg_pkg;

  // Cell storage
  localparam int CELL_W = 3;
  typedef logic [CELL_W-1:0] cell_t;

  // Request field widths and codes
  localparam int REQ_W   = 2;
  localparam int COORD_W = 6;
  typedef logic [REQ_W-1:0] req_code_t;
  localparam req_code_t REQ_WRITE   = 2'd0;
  localparam req_code_t REQ_READ    = 2'd1;
  localparam req_code_t REQ_ADVANCE = 2'd2;

  // Configuration registers
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BOARD_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_BOARD_HEIGHT = 2'd1;
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
  localparam int MIN_DIM = 3;

  // Default storage size
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  // B3/S23 rule constants
  localparam int SURVIVE_MIN = 2;
  localparam int SURVIVE_MAX = 3;
  localparam int BIRTH_COUNT = 3;
  localparam int LIVE_OFFSET = 2;
  localparam int BIRTH_CODE  = 3;

  // 3x3 neighborhood handed to the cell rule unit
  typedef struct packed {
    cell_t [7:0] nbr;
    cell_t       self;
  } window_t;

endpackage

// File: rtl/tlg_req_if.sv
`timescale 1ns / 1ps
interface tlg_req_if import tlg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [COORD_W-1:0]   cell_col;
  logic [COORD_W-1:0]   cell_row;
  logic [CELL_W-1:0]    cell_value;

  modport source (output valid, req_type, cell_col, cell_row, cell_value, input ready);
  modport sink   (input valid, req_type, cell_col, cell_row, cell_value, output ready);
endinterface

// File: rtl/tlg_res_if.sv
`timescale 1ns / 1ps
interface tlg_res_if import tlg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] read_value;
  logic              generation_done;

  modport source (output valid, read_value, generation_done, input ready);
  modport sink   (input valid, read_value, generation_done, output ready);
endinterface

// File: rtl/tlg_cfg_if.sv
`timescale 1ns / 1ps
interface tlg_cfg_if import tlg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/toroidal_life_generation_core.sv
`timescale 1ns / 1ps
// Toroidal B3/S23 life board.
// req channel: one transaction is a request: write a cell, read a cell or
//   advance one generation. res channel: exactly one transaction per
//   request, read_value for a read (else 0), generation_done for an advance.
// cfg channel: always ready; index 0 sets board_width, 1 sets board_height.
//   Values in use saturate to 3..MAX_COLS / 3..MAX_ROWS. Write only while idle.
// The board is held one row per RAM word; req.ready is high only when idle.
// In-store write/read: ST_ROW_RD, ST_ROW_USE, ST_FIN; unused code: ST_FIN only.
// An advance walks a three-row window over the board, one cell per cycle
//   through the shared rule unit, plus one read and one write of the row
//   RAM per row.
// Reset: the RAM is cleared, one row per cycle, before the first request
//   is taken; width and height return to 64.
// A stalled receiver holds the result in the output register; the next
//   request is still taken, and its own result waits until the slot frees.
module toroidal_life_generation_core import tlg_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input logic       clk,
  input logic       rst,
  tlg_req_if.sink   req,
  tlg_res_if.source res,
  tlg_cfg_if.sink   cfg
);

  localparam int CW       = $clog2(MAX_COLS);
  localparam int RW       = $clog2(MAX_ROWS);
  localparam int ROW_BITS = MAX_COLS * CELL_W;
  localparam int CXW      = ((COORD_W > CW) ? COORD_W : CW) + 1;
  localparam int RXW      = ((COORD_W > RW) ? COORD_W : RW) + 1;
  localparam int WXW      = ((CW + 1) > DIM_W) ? (CW + 1) : DIM_W;
  localparam int HXW      = ((RW + 1) > DIM_W) ? (RW + 1) : DIM_W;

  typedef logic [MAX_COLS-1:0][CELL_W-1:0] row_t;

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_ROW_RD  = 4'd2;
  localparam logic [3:0] ST_ROW_USE = 4'd3;
  localparam logic [3:0] ST_G_LAST  = 4'd4;
  localparam logic [3:0] ST_G_FIRST = 4'd5;
  localparam logic [3:0] ST_G_ZERO  = 4'd6;
  localparam logic [3:0] ST_G_ISSUE = 4'd7;
  localparam logic [3:0] ST_G_NEXT  = 4'd8;
  localparam logic [3:0] ST_G_CELL  = 4'd9;
  localparam logic [3:0] ST_G_WR    = 4'd10;
  localparam logic [3:0] ST_FIN     = 4'd11;

  logic [3:0]       state;
  logic [DIM_W-1:0] board_width;
  logic [DIM_W-1:0] board_height;
  logic [RW-1:0]    row_cnt;
  logic [CW-1:0]    col_cnt;
  row_t             prev_row, cur_row, nxt_row, first_row, out_row;
  req_code_t        req_q;
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  cell_t            val_q;
  cell_t            res_rd;
  logic             res_done;
  logic             out_valid;
  cell_t            out_read_value;
  logic             out_done;

  // Saturated board dimensions
  logic [WXW-1:0] bw_x;
  logic [HXW-1:0] bh_x;
  logic [WXW-1:0] w_sat;
  logic [HXW-1:0] h_sat;
  logic [CW:0]    w_use;
  logic [RW:0]    h_use;

  assign bw_x = WXW'(board_width);
  assign bh_x = HXW'(board_height);

  always_comb begin
    if (bw_x < WXW'(MIN_DIM)) begin
      w_sat = WXW'(MIN_DIM);
    end else if (bw_x > WXW'(MAX_COLS)) begin
      w_sat = WXW'(MAX_COLS);
    end else begin
      w_sat = bw_x;
    end
    if (bh_x < HXW'(MIN_DIM)) begin
      h_sat = HXW'(MIN_DIM);
    end else if (bh_x > HXW'(MAX_ROWS)) begin
      h_sat = HXW'(MAX_ROWS);
    end else begin
      h_sat = bh_x;
    end
  end

  assign w_use = w_sat[CW:0];
  assign h_use = h_sat[RW:0];

  // Request decode
  logic           req_fire;
  logic [CXW-1:0] col_x;
  logic [RXW-1:0] row_x;
  logic           in_store;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign col_x     = CXW'(req.cell_col);
  assign row_x     = RXW'(req.cell_row);
  assign in_store  = (col_x < CXW'(MAX_COLS)) && (row_x < RXW'(MAX_ROWS));

  // Window position and wrap
  logic          row_is_last;
  logic          col_is_last;
  logic [CW-1:0] col_m, col_p;
  logic [RW-1:0] h_last;

  assign row_is_last = ({1'b0, row_cnt} + (RW+1)'(1)) == h_use;
  assign col_is_last = ({1'b0, col_cnt} + (CW+1)'(1)) == w_use;
  assign h_last      = RW'(h_use - (RW+1)'(1));
  assign col_m       = (col_cnt == '0) ? CW'(w_use - (CW+1)'(1)) : col_cnt - CW'(1);
  assign col_p       = col_is_last ? '0 : col_cnt + CW'(1);

  // Shared cell rule unit
  window_t win;
  cell_t   new_cell;

  always_comb begin
    win.nbr[0] = prev_row[col_m];
    win.nbr[1] = prev_row[col_cnt];
    win.nbr[2] = prev_row[col_p];
    win.nbr[3] = cur_row[col_m];
    win.nbr[4] = cur_row[col_p];
    win.nbr[5] = nxt_row[col_m];
    win.nbr[6] = nxt_row[col_cnt];
    win.nbr[7] = nxt_row[col_p];
    win.self   = cur_row[col_cnt];
  end

  tlg_cell_rule u_rule (
    .win       (win),
    .next_cell (new_cell)
  );

  // Row RAM
  logic                wr_en, rd_en;
  logic [RW-1:0]       wr_addr, rd_addr;
  logic [ROW_BITS-1:0] wr_data, rd_data;
  row_t                rd_row, mod_row;

  assign rd_row = rd_data;

  always_comb begin
    mod_row        = rd_row;
    mod_row[col_q] = val_q;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = row_cnt;
    wr_data = out_row;
    rd_en   = 1'b0;
    rd_addr = row_cnt;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      ST_ROW_RD: begin
        rd_en   = 1'b1;
        rd_addr = row_q;
      end
      ST_ROW_USE: begin
        wr_en   = (req_q == REQ_WRITE);
        wr_addr = row_q;
        wr_data = mod_row;
      end
      ST_G_LAST: begin
        rd_en   = 1'b1;
        rd_addr = h_last;
      end
      ST_G_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      ST_G_ISSUE: begin
        rd_en   = !row_is_last;
        rd_addr = row_cnt + RW'(1);
      end
      ST_G_WR: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tlg_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_width  <= DIM_RESET;
      board_height <= DIM_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_BOARD_WIDTH) begin
        board_width <= cfg.data;
      end else if (cfg.index == CFG_BOARD_HEIGHT) begin
        board_height <= cfg.data;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      row_cnt <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (row_cnt == RW'(MAX_ROWS - 1)) begin
            row_cnt <= '0;
            state   <= ST_IDLE;
          end else begin
            row_cnt <= row_cnt + RW'(1);
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            if ((req.req_type == REQ_WRITE || req.req_type == REQ_READ) && in_store) begin
              state <= ST_ROW_RD;
            end else if (req.req_type == REQ_ADVANCE) begin
              state <= ST_G_LAST;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_ROW_RD:  state <= ST_ROW_USE;
        ST_ROW_USE: state <= ST_FIN;
        ST_G_LAST:  state <= ST_G_FIRST;
        ST_G_FIRST: state <= ST_G_ZERO;
        ST_G_ZERO: begin
          row_cnt <= '0;
          state   <= ST_G_ISSUE;
        end
        ST_G_ISSUE: state <= ST_G_NEXT;
        ST_G_NEXT:  state <= ST_G_CELL;
        ST_G_CELL: begin
          if (col_is_last) begin
            state <= ST_G_WR;
          end
        end
        ST_G_WR: begin
          if (row_is_last) begin
            row_cnt <= '0;
            state   <= ST_FIN;
          end else begin
            row_cnt <= row_cnt + RW'(1);
            state   <= ST_G_ISSUE;
          end
        end
        ST_FIN: begin
          if (!out_valid || res.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_q    <= req.req_type;
      col_q    <= col_x[CW-1:0];
      row_q    <= row_x[RW-1:0];
      val_q    <= req.cell_value;
      res_rd   <= '0;
      res_done <= (req.req_type == REQ_ADVANCE);
    end
    if (state == ST_ROW_USE && req_q == REQ_READ) begin
      res_rd <= rd_row[col_q];
    end
    if (state == ST_G_FIRST) begin
      prev_row <= rd_row;
    end
    if (state == ST_G_ZERO) begin
      cur_row   <= rd_row;
      first_row <= rd_row;
    end
    if (state == ST_G_NEXT) begin
      nxt_row <= row_is_last ? first_row : rd_row;
      out_row <= cur_row;
      col_cnt <= '0;
    end
    if (state == ST_G_CELL) begin
      out_row[col_cnt] <= new_cell;
      col_cnt          <= col_cnt + CW'(1);
    end
    if (state == ST_G_WR) begin
      prev_row <= cur_row;
      cur_row  <= nxt_row;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && (!out_valid || res.ready)) begin
      out_valid <= 1'b1;
    end else if (out_valid && res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!out_valid || res.ready)) begin
      out_read_value <= res_rd;
      out_done       <= res_done;
    end
  end

  assign res.valid           = out_valid;
  assign res.read_value      = out_read_value;
  assign res.generation_done = out_done;

`ifndef SYNTH
  // The cell walk never leaves the columns in use
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_G_CELL) |-> ({1'b0, col_cnt} < w_use))
    else $error("cell walk column beyond board width");

  // No RAM write while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !wr_en)
    else $error("RAM written while idle");

  // An accepted request always leaves idle
  a_req_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // Finishing with a free slot presents a result
  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && (!out_valid || res.ready)) |=> out_valid)
    else $error("finished request produced no result");
`endif

endmodule

// File: rtl/tlg_ram.sv
`timescale 1ns / 1ps
module tlg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/tlg_cell_rule.sv
`timescale 1ns / 1ps
module tlg_cell_rule import tlg_pkg::*; (
  input  window_t win,
  output cell_t   next_cell
);

  logic [3:0] cnt;

  // Count live neighbors, then apply birth/survival with display codes
  always_comb begin
    cnt = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + {3'b000, |win.nbr[i]};
    end
    if (|win.self) begin
      if (cnt == 4'(SURVIVE_MIN) || cnt == 4'(SURVIVE_MAX)) begin
        next_cell = CELL_W'(cnt + 4'(LIVE_OFFSET));
      end else begin
        next_cell = '0;
      end
    end else if (cnt == 4'(BIRTH_COUNT)) begin
      next_cell = CELL_W'(BIRTH_CODE);
    end else begin
      next_cell = '0;
    end
  end

endmodule
